>>> rtl/core/udaf_pkg.sv
`default_nettype none

package udaf_pkg;

  // Field widths of the beats
  localparam int VALUE_W   = 32;
  localparam int FWIDTH_W  = 5;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 4;
  localparam int NEED_W    = 4;

  // Decimal conversion
  localparam int NUM_DIGITS = 10;
  localparam int BITCNT_W   = $clog2(VALUE_W);
  localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(VALUE_W - 1);
  localparam logic [CHAR_W-1:0]   ASCII_ZERO = 8'd48;

  // Field width limits: the width is clamped to the smaller of the two
  localparam int MAX_WIDTH    = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int WIDTH_CAP_I  = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;
  localparam logic [FWIDTH_W-1:0] WIDTH_CAP = FWIDTH_W'(WIDTH_CAP_I);

  // Queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // One converted item waiting for emission
  typedef struct packed {
    bcd_t                digits;
    logic [FWIDTH_W-1:0] len;
    logic [NEED_W-1:0]   need;
    logic                too_small;
  } q_entry_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } fr_state_t;

endpackage

`default_nettype wire

>>> rtl/core/udaf_in_if.sv
`default_nettype none

interface udaf_in_if;
  logic                               valid;
  logic                               ready;
  logic [udaf_pkg::VALUE_W-1:0]       value;
  logic [udaf_pkg::FWIDTH_W-1:0]      field_width;
  logic                               align_left;

  modport source (output valid, value, field_width, align_left, input ready);
  modport sink   (input valid, value, field_width, align_left, output ready);
endinterface

`default_nettype wire

>>> rtl/core/udaf_out_if.sv
`default_nettype none

interface udaf_out_if;
  logic                           valid;
  logic                           ready;
  logic [udaf_pkg::CHAR_W-1:0]    character;
  logic [udaf_pkg::POS_W-1:0]     position;
  logic                           char_valid;
  logic [udaf_pkg::NEED_W-1:0]    digits_needed;
  logic                           too_small;
  logic                           last;

  modport source (output valid, character, position, char_valid, digits_needed,
                  too_small, last, input ready);
  modport sink   (input valid, character, position, char_valid, digits_needed,
                  too_small, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/udaf_front.sv
`default_nettype none

module udaf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  udaf_in_if.sink            in_item,
  output udaf_pkg::q_entry_t push_entry,
  output logic               push_valid,
  input  wire logic          push_ready
);

  udaf_pkg::fr_state_t                 state, state_next;
  logic [udaf_pkg::VALUE_W-1:0]        shreg;
  udaf_pkg::bcd_t                      bcd;
  udaf_pkg::bcd_t                      bcd_adj;
  logic [4*udaf_pkg::NUM_DIGITS-1:0]   bcd_adj_flat;
  logic [udaf_pkg::BITCNT_W-1:0]       bitcnt;
  logic [udaf_pkg::FWIDTH_W-1:0]       width;
  logic                                align;
  logic [udaf_pkg::NEED_W-1:0]         need;
  logic                                accept;

  assign accept = in_item.valid && in_item.ready;

  // Add-3 correction on every digit ahead of the shift
  always_comb begin
    for (int k = 0; k < udaf_pkg::NUM_DIGITS; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  assign bcd_adj_flat = bcd_adj;

  // Digit count: highest nonzero digit, zero still needs one
  always_comb begin
    need = 4'd1;
    for (int k = 0; k < udaf_pkg::NUM_DIGITS; k++) begin
      if (bcd[k] != 4'd0) need = udaf_pkg::NEED_W'(k + 1);
    end
  end

  // Entry handed to the queue
  always_comb begin
    push_entry.digits    = bcd;
    push_entry.need      = need;
    push_entry.too_small = (width == '0) || ({1'b0, need} > width);
    push_entry.len       = align ? {1'b0, need} : width;
  end

  // Control
  always_comb begin
    state_next    = state;
    push_valid    = 1'b0;
    in_item.ready = 1'b0;
    unique case (state)
      udaf_pkg::FR_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) state_next = udaf_pkg::FR_CONV;
      end
      udaf_pkg::FR_CONV: begin
        if (bitcnt == udaf_pkg::LAST_BIT) state_next = udaf_pkg::FR_PUSH;
      end
      udaf_pkg::FR_PUSH: begin
        push_valid    = 1'b1;
        in_item.ready = push_ready;
        if (push_ready) begin
          state_next = in_item.valid ? udaf_pkg::FR_CONV : udaf_pkg::FR_IDLE;
        end
      end
      default: state_next = udaf_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= udaf_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load on accept, one bit per cycle while converting
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg  <= in_item.value;
      bcd    <= '0;
      bitcnt <= '0;
      width  <= (in_item.field_width > udaf_pkg::WIDTH_CAP) ?
                udaf_pkg::WIDTH_CAP : in_item.field_width;
      align  <= in_item.align_left;
    end else if (state == udaf_pkg::FR_CONV) begin
      bcd    <= {bcd_adj_flat[4*udaf_pkg::NUM_DIGITS-2:0], shreg[udaf_pkg::VALUE_W-1]};
      shreg  <= {shreg[udaf_pkg::VALUE_W-2:0], 1'b0};
      bitcnt <= bitcnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/udaf_queue.sv
`default_nettype none

module udaf_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire udaf_pkg::q_entry_t push_entry,
  input  wire logic               push_valid,
  output logic                    push_ready,
  output udaf_pkg::q_entry_t      pop_entry,
  output logic                    pop_valid,
  input  wire logic               pop_ready
);

  udaf_pkg::q_entry_t                entries [udaf_pkg::QDEPTH];
  logic [udaf_pkg::QPTR_W-1:0]       wptr;
  logic [udaf_pkg::QPTR_W-1:0]       rptr;
  logic [udaf_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (count != udaf_pkg::QCNT_W'(udaf_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push_entry;
  end

endmodule

`default_nettype wire

>>> rtl/core/udaf_back.sv
`default_nettype none

module udaf_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire udaf_pkg::q_entry_t entry,
  input  wire logic               entry_valid,
  output logic                    entry_done,
  udaf_out_if.source              out_item
);

  logic [udaf_pkg::POS_W-1:0]    pos;
  logic [udaf_pkg::FWIDTH_W-1:0] pos_ext;
  logic [udaf_pkg::FWIDTH_W-1:0] idx;
  logic [3:0]                    digit;
  logic                          is_last;
  logic                          take;
  logic                          ovalid;

  assign pos_ext = {1'b0, pos};
  // digit counted from the least significant end
  assign idx     = entry.len - pos_ext - 5'd1;
  assign digit   = (idx < udaf_pkg::FWIDTH_W'(udaf_pkg::NUM_DIGITS)) ?
                   entry.digits[idx[3:0]] : 4'd0;
  assign is_last = entry.too_small || (pos_ext + 5'd1 == entry.len);

  assign take       = entry_valid && (!ovalid || out_item.ready);
  assign entry_done = take && is_last;
  assign out_item.valid = ovalid;

  // Position counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (take) begin
        ovalid <= 1'b1;
      end else if (out_item.ready) begin
        ovalid <= 1'b0;
      end
      if (take) pos <= is_last ? '0 : pos + 1'b1;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (take) begin
      out_item.digits_needed <= entry.need;
      out_item.too_small     <= entry.too_small;
      out_item.last          <= is_last;
      if (entry.too_small) begin
        out_item.character  <= '0;
        out_item.position   <= '0;
        out_item.char_valid <= 1'b0;
      end else begin
        out_item.character  <= udaf_pkg::ASCII_ZERO + {4'd0, digit};
        out_item.position   <= pos;
        out_item.char_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/unsigned_decimal_ascii_formatter.sv
`default_nettype none

// Channel   Dir  Beat payload
// in_item   in   value[31:0], field_width[4:0], align_left
// out_item  out  character[7:0], position[3:0], char_valid, digits_needed[3:0],
//                too_small, last
//
// In the front an item passes the accept, 32 shift-and-correct steps of the
// binary to decimal converter, and a push to the queue. The back then sends
// one beat a cycle while the output is ready: the field length, or one beat
// when the field is too small. A two-entry queue lets emission overlap the
// next conversion; either side stalls only on a full queue or stalled output.
// Synchronous reset clears the control state only.

module unsigned_decimal_ascii_formatter (
  input  wire logic  clk,
  input  wire logic  rst,
  udaf_in_if.sink    in_item,
  udaf_out_if.source out_item
);

  udaf_pkg::q_entry_t push_entry;
  udaf_pkg::q_entry_t pop_entry;
  logic               push_valid;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;

  udaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  udaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  udaf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (pop_entry),
    .entry_valid (pop_valid),
    .entry_done  (pop_ready),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int N_RANDOM = 250;

  // one pending input beat
  typedef struct {
    logic [udaf_pkg::VALUE_W-1:0]  value;
    logic [udaf_pkg::FWIDTH_W-1:0] field_width;
    logic                          align_left;
    bit                            wait_drain;
  } fmt_job_t;

  // one expected output beat
  typedef struct packed {
    logic [udaf_pkg::CHAR_W-1:0] character;
    logic [udaf_pkg::POS_W-1:0]  position;
    logic                        char_valid;
    logic [udaf_pkg::NEED_W-1:0] digits_needed;
    logic                        too_small;
    logic                        last;
  } glyph_t;

  logic clk;
  logic rst;

  udaf_in_if  in_item ();
  udaf_out_if out_item ();

  unsigned_decimal_ascii_formatter u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_item (out_item)
  );

  fmt_job_t job_q[$];
  glyph_t   glyph_q[$];
  int       n_jobs;
  int       n_taken;
  int       n_err;
  logic     drained;

  // clock, reset and initial input levels
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_item.valid = 1'b0;
    in_item.value = '0;
    in_item.field_width = '0;
    in_item.align_left = 1'b0;
    out_item.ready = 1'b0;
    fork
      forever #4 clk = ~clk;
      begin
        repeat (11) @(posedge clk);
        rst <= 1'b0;
      end
    join
  end

  // idling phases: none, sender gaps, receiver stalls, both lightly
  function automatic int run_phase();
    int ph;
    ph = (n_taken * 4) / ((n_jobs > 0) ? n_jobs : 1);
    return (ph > 3) ? 3 : ph;
  endfunction

  function automatic bit src_gap();
    int pct;
    case (run_phase())
      1:       pct = 85;
      3:       pct = 15;
      default: pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sink_stall();
    int pct;
    case (run_phase())
      2:       pct = 85;
      3:       pct = 15;
      default: pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // expected beats for one value
  function automatic void predict_field(input logic [udaf_pkg::VALUE_W-1:0] v,
                                        input logic [udaf_pkg::FWIDTH_W-1:0] fw,
                                        input logic left);
    int unsigned w;
    int unsigned need;
    int unsigned len;
    int unsigned rest;
    int          i;
    logic [3:0]  dig [udaf_pkg::RESULT_LIMIT];
    glyph_t      g;
    w = fw;
    if (w > udaf_pkg::MAX_WIDTH) w = udaf_pkg::MAX_WIDTH;
    if (w > udaf_pkg::RESULT_LIMIT) w = udaf_pkg::RESULT_LIMIT;
    rest = v;
    need = 0;
    do begin
      need++;
      rest = rest / 10;
    end while (rest != 0);
    if (w == 0 || need > w) begin
      g = '{character: '0, position: '0, char_valid: 1'b0,
            digits_needed: udaf_pkg::NEED_W'(need), too_small: 1'b1, last: 1'b1};
      glyph_q.push_back(g);
      return;
    end
    len = left ? need : w;
    // least significant digit goes to the rightmost position
    rest = v;
    for (i = int'(len) - 1; i >= 0; i--) begin
      dig[i] = 4'(rest % 10);
      rest = rest / 10;
    end
    for (i = 0; i < int'(len); i++) begin
      g.character = udaf_pkg::ASCII_ZERO + udaf_pkg::CHAR_W'(dig[i]);
      g.position = udaf_pkg::POS_W'(i);
      g.char_valid = 1'b1;
      g.digits_needed = udaf_pkg::NEED_W'(need);
      g.too_small = 1'b0;
      g.last = (i + 1 == int'(len));
      glyph_q.push_back(g);
    end
  endfunction

  task automatic report_field(input string fld, input logic [31:0] e, input logic [31:0] a);
    n_err++;
    $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, fld, e, a);
  endtask

  // driver: hold valid until taken, gaps and drain pauses between beats
  always @(posedge clk) begin
    if (rst) begin
      in_item.valid <= 1'b0;
    end else if (!in_item.valid || in_item.ready) begin
      if (job_q.size() != 0 &&
          (!job_q[0].wait_drain || (!in_item.valid && drained)) && !src_gap()) begin
        in_item.valid <= 1'b1;
        in_item.value <= job_q[0].value;
        in_item.field_width <= job_q[0].field_width;
        in_item.align_left <= job_q[0].align_left;
        void'(job_q.pop_front());
      end else begin
        in_item.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_item.ready <= 1'b0;
    end else begin
      out_item.ready <= !sink_stall();
    end
  end

  // monitor: predict on input beats, check output beats in order
  always @(posedge clk) begin
    glyph_t e;
    if (rst) begin
      drained <= 1'b1;
      n_taken <= 0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        predict_field(in_item.value, in_item.field_width, in_item.align_left);
        n_taken <= n_taken + 1;
      end
      if (out_item.valid && out_item.ready) begin
        if (glyph_q.size() == 0) begin
          n_err++;
          $display("%0t unexpected beat: expected none, got char 0x%0h pos %0d",
                   $time, out_item.character, out_item.position);
        end else begin
          e = glyph_q.pop_front();
          if (out_item.character !== e.character)
            report_field("character", e.character, out_item.character);
          if (out_item.position !== e.position)
            report_field("position", e.position, out_item.position);
          if (out_item.char_valid !== e.char_valid)
            report_field("char_valid", e.char_valid, out_item.char_valid);
          if (out_item.digits_needed !== e.digits_needed)
            report_field("digits_needed", e.digits_needed, out_item.digits_needed);
          if (out_item.too_small !== e.too_small)
            report_field("too_small", e.too_small, out_item.too_small);
          if (out_item.last !== e.last)
            report_field("last", e.last, out_item.last);
        end
      end
      drained <= (glyph_q.size() == 0);
    end
  end

  function automatic void add_job(input logic [udaf_pkg::VALUE_W-1:0] v, input int fw,
                                  input logic left, input bit hold);
    fmt_job_t j;
    j.value = v;
    j.field_width = udaf_pkg::FWIDTH_W'(fw);
    j.align_left = left;
    j.wait_drain = hold;
    job_q.push_back(j);
  endfunction

  // random value of a chosen digit count, field mostly wide enough
  function automatic void add_random_job(input bit hold);
    int     d;
    int     need;
    longint lo;
    longint hi;
    logic [udaf_pkg::VALUE_W-1:0] v;
    int     fw;
    d = $urandom_range(10, 1);
    lo = 1;
    for (int i = 1; i < d; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (d == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    case ($urandom_range(9))
      0:       v = $urandom();
      1:       v = '0;
      default: v = udaf_pkg::VALUE_W'($urandom_range(32'(hi), 32'(lo)));
    endcase
    need = 1;
    for (longint r = v / 10; r != 0; r = r / 10) need++;
    case ($urandom_range(9))
      0, 1:    fw = $urandom_range(31);
      2:       fw = $urandom_range(need);
      default: fw = $urandom_range(udaf_pkg::MAX_WIDTH, need);
    endcase
    add_job(v, fw, 1'($urandom_range(1)), hold);
  endfunction

  // stimulus and end of run
  initial begin
    // extremes, empty and short fields, saturated widths, zero
    add_job(32'd0, 1, 1'b1, 1'b0);
    add_job(32'd0, 1, 1'b0, 1'b0);
    add_job(32'd0, 0, 1'b1, 1'b0);
    add_job(32'd0, 16, 1'b0, 1'b0);
    add_job(32'hFFFF_FFFF, 10, 1'b1, 1'b0);
    add_job(32'hFFFF_FFFF, 16, 1'b0, 1'b0);
    add_job(32'hFFFF_FFFF, 9, 1'b1, 1'b0);
    add_job(32'hFFFF_FFFF, 31, 1'b0, 1'b0);
    add_job(32'd9, 1, 1'b0, 1'b0);
    add_job(32'd10, 1, 1'b1, 1'b0);
    add_job(32'd10, 2, 1'b0, 1'b0);
    add_job(32'd99, 16, 1'b1, 1'b0);
    add_job(32'd100, 3, 1'b0, 1'b0);
    add_job(32'd999_999_999, 9, 1'b1, 1'b0);
    add_job(32'd1_000_000_000, 10, 1'b0, 1'b0);
    add_job(32'd1_000_000_000, 17, 1'b1, 1'b0);
    add_job(32'd12345, 16, 1'b0, 1'b0);
    add_job(32'd5, 16, 1'b0, 1'b0);
    add_job(32'd7, 0, 1'b0, 1'b0);
    add_job(32'h5555_5555, 20, 1'b0, 1'b0);
    add_job(32'hAAAA_AAAA, 15, 1'b1, 1'b0);
    add_job(32'd65535, 8, 1'b0, 1'b0);
    add_job(32'd4_000_000_000, 31, 1'b1, 1'b0);
    for (int i = 0; i < N_RANDOM; i++)
      add_random_job(i == 0 || i == N_RANDOM / 2 || $urandom_range(99) < 2);
    n_jobs = job_q.size();

    @(negedge clk);
    while (rst) @(negedge clk);
    while (job_q.size() != 0 || in_item.valid || !drained) @(negedge clk);
    repeat (60) @(negedge clk);
    if (glyph_q.size() != 0) begin
      n_err++;
      $display("%0t %0d expected beats never came, first: char 0x%0h pos %0d",
               $time, glyph_q.size(), glyph_q[0].character, glyph_q[0].position);
    end
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> unsigned_decimal_ascii_formatter.f
rtl/core/udaf_pkg.sv
rtl/core/udaf_in_if.sv
rtl/core/udaf_out_if.sv
rtl/core/udaf_front.sv
rtl/core/udaf_queue.sv
rtl/core/udaf_back.sv
rtl/core/unsigned_decimal_ascii_formatter.sv
bench/tb_top.sv
